>>> hdl/bba_pkg.sv
// Shared types, constants and helpers for the bitmap block allocator.
package bba_pkg;

	localparam int MAX_BLOCKS  = 64;
	localparam int ALIGN_BYTES = 8;

	localparam int MAP_W     = 64;
	localparam int EFF_MAX   = (MAX_BLOCKS < MAP_W) ? MAX_BLOCKS : MAP_W;
	localparam int IDX_W     = 6;
	localparam int CNT_W     = 7;
	localparam int BSIZE_W   = 13;
	localparam int SPAN_W    = BSIZE_W + CNT_W;
	localparam int GRP_LANES = 8;
	localparam int GRP_N     = MAP_W / GRP_LANES;
	localparam int GRP_W     = $clog2(GRP_N);
	localparam int LANE_W    = $clog2(GRP_LANES);
	localparam int QSTEP_W   = $clog2(IDX_W);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam int SIZE_MAX  = 4096;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_NO_FREE      = 2'd1;
	localparam logic [1:0] ST_OUTSIDE      = 2'd2;
	localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

	typedef struct packed {
		logic        action;
		logic        for_hw;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] block_index;
		logic [31:0]      block_address;
		logic [CNT_W-1:0] free_count;
		logic [CNT_W-1:0] used_count;
	} rsp_t;

	typedef struct packed {
		logic               start;
		logic [SPAN_W-1:0]  dividend;
		logic [BSIZE_W-1:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] quotient;
	} div_res_t;

	function automatic logic [BSIZE_W-1:0] align_size(input logic [12:0] d);
		logic [13:0] c;
		c = {1'b0, d};
		if (c == 14'd0)
			c = 14'd1;
		else if (c > 14'(SIZE_MAX))
			c = 14'(SIZE_MAX);
		return BSIZE_W'(((32'(c) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES);
	endfunction

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
		return (v > CNT_W'(EFF_MAX)) ? CNT_W'(EFF_MAX) : v;
	endfunction

endpackage

>>> hdl/bba_div.sv
// Iterative restoring divider: one quotient bit per cycle.
module bba_div
	import bba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_cmd_t cmd,
	output div_res_t res
);

	logic               busy_q;
	logic               done_q;
	logic [QSTEP_W-1:0] k_q;
	logic [SPAN_W-1:0]  rem_q;
	logic [IDX_W-1:0]   quot_q;
	logic [SPAN_W-1:0]  shifted;
	logic               ge;

	always_comb begin
		shifted = {{(SPAN_W-BSIZE_W){1'b0}}, cmd.divisor} << k_q;
		ge = (rem_q >= shifted);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				k_q    <= QSTEP_W'(IDX_W - 1);
			end else if (busy_q) begin
				if (k_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					k_q <= k_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q  <= cmd.dividend;
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - shifted;
			quot_q[k_q] <= ge;
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quot_q;

endmodule

>>> hdl/bitmap_block_allocator.sv
// Fixed-block pool allocator with free and hardware-ownership bitmaps.
//
// Requests come in on req_valid/req_ready: allocate takes the lowest free
// block, free maps a byte address back to its block and releases it.
// Each request yields exactly one response on rsp_valid/rsp_ready with a
// status, the block index and address, and the free and used counts.
// One request is in flight at a time; req_ready is high only when idle.
// Allocate searches the free map eight blocks per cycle, then multiplies
// index by block size; with no free block it answers once the whole map is
// searched. Free range-checks the pool offset, the six-step divider turns
// it into a block index, then the same multiply runs; a block already free
// skips the multiply, an address outside the pool skips the divider too.
// A new request can be taken in the cycle after the response is
// registered. The response sits in an output register; while rsp_ready is
// low the block holds it, and a finished request waits in its final step.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// a write to a defined register re-initializes both maps. They must be
// issued only while idle; the block does not enforce it. Reset: base 0,
// data size 64, block count 64, all blocks free and unowned.
module bitmap_block_allocator
	import bba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_SPAN = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]         state_q;
	logic [31:0]        base_q;
	logic [BSIZE_W-1:0] bsize_q;
	logic [CNT_W-1:0]   n_q;
	logic [MAP_W-1:0]   free_map_q;
	logic [MAP_W-1:0]   hw_map_q;
	logic [CNT_W-1:0]   fc_q;
	req_t               req_q;
	logic [GRP_W-1:0]   grp_q;
	logic [IDX_W-1:0]   idx_q;
	logic [1:0]         status_q;
	logic [31:0]        offset_q;
	logic [SPAN_W-1:0]  span_q;
	logic [SPAN_W-1:0]  prod_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [CNT_W-1:0]     n_new;
	logic [MAP_W-1:0]     init_map;
	logic [GRP_LANES-1:0] grp_bits;
	logic                 grp_hit;
	logic [LANE_W-1:0]    lane;
	logic [CNT_W-1:0]     fc_next;
	logic                 out_free;
	logic                 in_range;
	div_cmd_t             div_cmd;
	div_res_t             div_res;

	assign n_new = (cfg_index == REG_BLOCK_COUNT) ? clamp_count(cfg_data[CNT_W-1:0]) : n_q;

	always_comb begin
		for (int i = 0; i < MAP_W; i++)
			init_map[i] = (CNT_W'(i) < n_new);
	end

	always_comb begin
		grp_bits = free_map_q[grp_q*GRP_LANES +: GRP_LANES];
		grp_hit  = |grp_bits;
		lane     = '0;
		for (int i = GRP_LANES - 1; i >= 0; i--)
			if (grp_bits[i])
				lane = LANE_W'(i);
	end

	always_comb begin
		fc_next = fc_q;
		if (status_q == ST_OK)
			fc_next = (req_q.action == ACT_FREE) ? fc_q + 1'b1 : fc_q - 1'b1;
	end

	assign out_free = !rsp_valid_q || rsp_ready;
	assign in_range = (offset_q < {{(32-SPAN_W){1'b0}}, span_q});

	assign div_cmd.start    = (state_q == S_CHK) && in_range;
	assign div_cmd.dividend = offset_q[SPAN_W-1:0];
	assign div_cmd.divisor  = bsize_q;

	bba_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			bsize_q     <= align_size(13'd64);
			n_q         <= clamp_count(7'd64);
			free_map_q  <= {MAP_W{1'b1}} >> (MAP_W - EFF_MAX);
			hw_map_q    <= '0;
			fc_q        <= CNT_W'(EFF_MAX);
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_POOL_BASE:   base_q  <= cfg_data;
					REG_DATA_SIZE:   bsize_q <= align_size(cfg_data[12:0]);
					REG_BLOCK_COUNT: n_q     <= n_new;
					default: ;
				endcase
				if (cfg_index == REG_POOL_BASE || cfg_index == REG_DATA_SIZE ||
					cfg_index == REG_BLOCK_COUNT) begin
					free_map_q <= init_map;
					hw_map_q   <= '0;
					fc_q       <= n_new;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid)
						state_q <= (req.action == ACT_FREE) ? S_SPAN : S_SCAN;
				end
				S_SCAN: begin
					if (grp_hit)
						state_q <= S_MUL;
					else if (grp_q == GRP_W'(GRP_N - 1))
						state_q <= S_DONE;
				end
				S_SPAN: state_q <= S_CHK;
				S_CHK:  state_q <= in_range ? S_DIV : S_DONE;
				S_DIV: begin
					if (div_res.done)
						state_q <= free_map_q[div_res.quotient] ? S_DONE : S_MUL;
				end
				S_MUL: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						fc_q    <= fc_next;
						if (status_q == ST_OK) begin
							if (req_q.action == ACT_FREE) begin
								free_map_q[idx_q] <= 1'b1;
								hw_map_q[idx_q]   <= 1'b0;
							end else begin
								free_map_q[idx_q] <= 1'b0;
								if (req_q.for_hw)
									hw_map_q[idx_q] <= 1'b1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q <= req;
				grp_q <= '0;
			end
			S_SCAN: begin
				if (grp_hit) begin
					idx_q    <= {grp_q, lane};
					status_q <= ST_OK;
				end else begin
					grp_q    <= grp_q + 1'b1;
					status_q <= ST_NO_FREE;
				end
			end
			S_SPAN: begin
				span_q   <= SPAN_W'(bsize_q) * SPAN_W'(n_q);
				offset_q <= req_q.address - base_q;
			end
			S_CHK: begin
				if (!in_range)
					status_q <= ST_OUTSIDE;
			end
			S_DIV: begin
				if (div_res.done) begin
					idx_q    <= div_res.quotient;
					status_q <= free_map_q[div_res.quotient] ? ST_ALREADY_FREE : ST_OK;
				end
			end
			S_MUL: prod_q <= SPAN_W'(idx_q) * SPAN_W'(bsize_q);
			S_DONE: begin
				if (out_free) begin
					rsp_q.status     <= status_q;
					rsp_q.free_count <= fc_next;
					rsp_q.used_count <= n_q - fc_next;
					if (status_q == ST_OK) begin
						rsp_q.block_index   <= idx_q;
						rsp_q.block_address <= base_q + {{(32-SPAN_W){1'b0}}, prod_q};
					end else begin
						rsp_q.block_index   <= '0;
						rsp_q.block_address <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> hdl/bba_check.sv
// Port-level checks for the bitmap block allocator, bound to the top level.
module bba_check
	import bba_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input rsp_t                 rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("new request taken while one is in flight");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |->
		(rsp.block_index == '0) && (rsp.block_address == '0))
		else $error("failed request returned a block");

	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
		({1'b0, rsp.free_count} + {1'b0, rsp.used_count}) <= (CNT_W+1)'(EFF_MAX))
		else $error("free plus used exceeds pool size");

endmodule

bind bitmap_block_allocator bba_check u_bba_check (.*);

>>> tb/alloc_checker.sv
// Bitmap allocator checker: tracks pool state, predicts each response, compares.
module alloc_checker
	import bba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  req_t                 req,
	input  logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  rsp_t                 rsp,
	output int                   mismatches,
	output int                   outstanding
);

	logic [31:0]      pool_base;
	logic [12:0]      size_reg;
	logic [CNT_W-1:0] count_reg;
	logic [MAP_W-1:0] free_blocks;
	logic [MAP_W-1:0] hw_owned;
	rsp_t             awaited_rsp[$];

	function automatic int live_blocks();
		return (count_reg > EFF_MAX) ? EFF_MAX : int'(count_reg);
	endfunction

	function automatic logic [MAP_W-1:0] fresh_map();
		int n;
		n = live_blocks();
		return (n >= MAP_W) ? {MAP_W{1'b1}} : ((MAP_W'(1) << n) - MAP_W'(1));
	endfunction

	// Applies one request to the tracked pool and returns the response it should give.
	function automatic rsp_t serve_request(input req_t r);
		rsp_t        e;
		int          n;
		int          d;
		int          i;
		int          b;
		int          fc;
		bit          found;
		logic [63:0] stride;
		logic [63:0] span;
		logic [31:0] off32;
		n = live_blocks();
		d = (size_reg == 0) ? 1 : (size_reg > SIZE_MAX) ? SIZE_MAX : int'(size_reg);
		stride = 64'((d + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES);
		e = '0;
		e.status = ST_NO_FREE;
		found = 1'b0;
		if (r.action == ACT_ALLOC) begin
			for (i = 0; i < n && !found; i++) begin
				if (free_blocks[i]) begin
					free_blocks[i] = 1'b0;
					if (r.for_hw)
						hw_owned[i] = 1'b1;
					e.block_index = IDX_W'(i);
					e.status = ST_OK;
					found = 1'b1;
				end
			end
		end else begin
			off32 = r.address - pool_base;
			span = stride * 64'(n);
			if (64'(off32) >= span) begin
				e.status = ST_OUTSIDE;
			end else begin
				b = int'(64'(off32) / stride);
				if (free_blocks[b]) begin
					e.status = ST_ALREADY_FREE;
				end else begin
					hw_owned[b] = 1'b0;
					free_blocks[b] = 1'b1;
					e.block_index = IDX_W'(b);
					e.status = ST_OK;
				end
			end
		end
		if (e.status == ST_OK)
			e.block_address = pool_base + 32'(e.block_index) * 32'(stride);
		fc = $countones(free_blocks);
		e.free_count = CNT_W'(fc);
		e.used_count = (n >= fc) ? CNT_W'(n - fc) : '0;
		return e;
	endfunction

	function automatic int field_differs(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		int   errs;
		if (!arst_n) begin
			pool_base = '0;
			size_reg = 13'd64;
			count_reg = 7'd64;
			free_blocks = fresh_map();
			hw_owned = '0;
			awaited_rsp.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;
			if (cfg_we) begin
				case (cfg_index)
					REG_POOL_BASE: pool_base = cfg_data;
					REG_DATA_SIZE: size_reg = cfg_data[12:0];
					REG_BLOCK_COUNT: count_reg = cfg_data[CNT_W-1:0];
					default: ;
				endcase
				if (cfg_index == REG_POOL_BASE || cfg_index == REG_DATA_SIZE ||
					cfg_index == REG_BLOCK_COUNT) begin
					free_blocks = fresh_map();
					hw_owned = '0;
				end
			end
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual %h", $time, rsp);
					errs++;
				end else begin
					want = awaited_rsp.pop_front();
					errs += field_differs("status", 32'(want.status), 32'(rsp.status));
					errs += field_differs("block_index", 32'(want.block_index),
						32'(rsp.block_index));
					errs += field_differs("block_address", want.block_address,
						rsp.block_address);
					errs += field_differs("free_count", 32'(want.free_count),
						32'(rsp.free_count));
					errs += field_differs("used_count", 32'(want.used_count),
						32'(rsp.used_count));
				end
			end
			if (req_valid && req_ready)
				awaited_rsp.push_back(serve_request(req));
			mismatches <= mismatches + errs;
			outstanding <= awaited_rsp.size();
		end
	end

endmodule

>>> tb/tb.sv
// Testbench top for the bitmap block allocator: clock, reset, stimulus and verdict.
module tb;
	import bba_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_REQS = 1600;
	localparam int QUIET_TAIL  = 150;
	localparam int CYCLE_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;
	int                   mismatches;
	int                   outstanding;

	int          cycle_count = 0;
	int          stall_left = 0;
	bit          gaps_on = 1'b0;
	bit          stalls_on = 1'b0;
	logic [31:0] cur_base = '0;
	logic [12:0] cur_size = 13'd64;
	logic [6:0]  cur_count = 7'd64;
	int          cur_n = 64;
	int          cur_stride = 64;

	bitmap_block_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	alloc_checker alloc_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** bitmap_block_allocator: FAILED **");
			$finish;
		end
	end

	// response back-pressure in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ready <= (stall_left == 1);
		end else if (stalls_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 6);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic set_pool(input logic [2:0] which, input logic [31:0] base_v,
		input logic [31:0] size_v, input logic [31:0] count_v, input bit spare);
		int d;
		if (which[0]) begin
			put_reg(REG_POOL_BASE, base_v);
			cur_base = base_v;
		end
		if (which[1]) begin
			put_reg(REG_DATA_SIZE, size_v);
			cur_size = size_v[12:0];
		end
		if (which[2]) begin
			put_reg(REG_BLOCK_COUNT, count_v);
			cur_count = count_v[6:0];
		end
		if (spare)
			put_reg(REG_SPARE, $urandom);
		cfg_we <= 1'b0;
		d = (cur_size == 0) ? 1 : (cur_size > SIZE_MAX) ? SIZE_MAX : int'(cur_size);
		cur_stride = (d + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
		cur_n = (cur_count > EFF_MAX) ? EFF_MAX : int'(cur_count);
	endtask

	// valid stays up between back-to-back requests; it drops only for a gap
	task automatic send_request(input logic act, input logic hw, input logic [31:0] addr);
		req_t r;
		r.action = act;
		r.for_hw = hw;
		r.address = addr;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic finish_phase();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		int          sent;
		int          phase_len;
		int          alloc_pct;
		int          pick;
		bit          quiet;
		logic        act;
		logic [31:0] addr;
		logic [31:0] base_v;
		logic [31:0] size_v;
		logic [31:0] count_v;
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// three 8-byte blocks straddling the top of the address space
		set_pool(3'b111, 32'hFFFF_FFF0, 32'd1, 32'd3, 1'b0);
		send_request(ACT_ALLOC, 1'b1, 32'h0000_0000);
		send_request(ACT_ALLOC, 1'b0, 32'hFFFF_FFFF);
		send_request(ACT_ALLOC, 1'b1, 32'h0000_0000);
		send_request(ACT_ALLOC, 1'b0, 32'h0000_0000);
		send_request(ACT_FREE, 1'b0, 32'hFFFF_FFF8);
		send_request(ACT_FREE, 1'b1, 32'hFFFF_FFFF);
		send_request(ACT_FREE, 1'b0, 32'hFFFF_FFEF);
		send_request(ACT_FREE, 1'b0, 32'h0000_0008);
		send_request(ACT_FREE, 1'b0, 32'h0000_0007);
		send_request(ACT_ALLOC, 1'b0, 32'h0000_0000);
		finish_phase();
		// unmapped index must leave the maps alone
		set_pool(3'b000, '0, '0, '0, 1'b1);
		send_request(ACT_ALLOC, 1'b1, 32'h0000_0000);
		finish_phase();

		// zero size and empty pool
		set_pool(3'b110, '0, 32'd0, 32'd0, 1'b0);
		send_request(ACT_ALLOC, 1'b1, 32'h0000_0000);
		send_request(ACT_FREE, 1'b0, 32'h0000_0000);
		send_request(ACT_FREE, 1'b0, 32'hFFFF_FFFF);
		finish_phase();

		// oversized size and count, junk in the upper data bits
		set_pool(3'b111, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_request(ACT_FREE, 1'b0, 32'h8003_FFFF);
		send_request(ACT_FREE, 1'b0, 32'h8004_0000);
		send_request(ACT_ALLOC, 1'b1, 32'hFFFF_FFFF);
		send_request(ACT_FREE, 1'b1, 32'h8000_0FFF);
		send_request(ACT_FREE, 1'b0, 32'h7FFF_FFFF);
		finish_phase();

		// largest exact size, last block wraps past 2^32
		set_pool(3'b111, 32'hFFFF_0000, 32'd4096, 32'd64, 1'b0);
		send_request(ACT_FREE, 1'b0, 32'h0002_F010);
		send_request(ACT_FREE, 1'b0, 32'h0003_0000);
		finish_phase();

		while (sent < RANDOM_REQS) begin
			quiet = (sent >= RANDOM_REQS - QUIET_TAIL);
			gaps_on = !quiet && $urandom_range(0, 3) != 0;
			stalls_on <= !quiet && $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 4))
				0: base_v = '0;
				1: base_v = 32'hFFFF_FFFF - $urandom_range(0, 4096);
				default: base_v = $urandom;
			endcase
			case ($urandom_range(0, 5))
				0: size_v = 32'd0;
				1: size_v = $urandom_range(4097, 8191);
				2: size_v = 32'd4096;
				3: size_v = $urandom_range(1, 16);
				default: size_v = $urandom_range(1, 4096);
			endcase
			case ($urandom_range(0, 7))
				0: count_v = 32'd0;
				1: count_v = $urandom_range(65, 127);
				2: count_v = 32'd64;
				3: count_v = 32'd1;
				default: count_v = $urandom_range(1, 12);
			endcase
			if ($urandom_range(0, 1))
				size_v = size_v | ($urandom & 32'hFFFF_E000);
			if ($urandom_range(0, 1))
				count_v = count_v | ($urandom & 32'hFFFF_FF80);
			set_pool(3'($urandom_range(0, 7)), base_v, size_v, count_v,
				$urandom_range(0, 7) == 0);
			case ($urandom_range(0, 2))
				0: alloc_pct = 30;
				1: alloc_pct = 55;
				default: alloc_pct = 85;
			endcase
			phase_len = $urandom_range(20, 120);
			repeat (phase_len) begin
				act = ($urandom_range(0, 99) < alloc_pct) ? ACT_ALLOC : ACT_FREE;
				addr = $urandom;
				if (act == ACT_FREE && cur_n > 0) begin
					pick = $urandom_range(0, 9);
					if (pick == 1) begin
						case ($urandom_range(0, 2))
							0: addr = cur_base - 32'd1;
							1: addr = cur_base + 32'(cur_n * cur_stride);
							default: addr = cur_base + 32'(cur_n * cur_stride) - 32'd1;
						endcase
					end else if (pick != 0) begin
						addr = cur_base + 32'($urandom_range(0, cur_n - 1) * cur_stride +
							$urandom_range(0, cur_stride - 1));
					end
				end
				send_request(act, 1'($urandom_range(0, 1)), addr);
				sent++;
			end
			finish_phase();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** bitmap_block_allocator: PASSED **");
		else
			$display("** bitmap_block_allocator: FAILED **");
		$finish;
	end

endmodule

>>> files.f
hdl/bba_pkg.sv
hdl/bba_div.sv
hdl/bitmap_block_allocator.sv
hdl/bba_check.sv
tb/alloc_checker.sv
tb/tb.sv
